>>> hw/rtl/mi3_pkg.sv
// Shared widths, element types and pipeline sideband for the 3x3 matrix inverse.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mi3_pkg;

   localparam int IN_W      = 16;
   localparam int FRAC_BITS = 8;
   localparam int OUT_W     = 32;
   localparam int N_ELEM    = 9;

   localparam int PROD_W  = 2 * IN_W;
   localparam int ADJ_W   = PROD_W + 1;
   localparam int DPROD_W = IN_W + ADJ_W;
   localparam int DET_W   = DPROD_W + 2;
   localparam int NUM_W   = ADJ_W + 2 * FRAC_BITS;
   localparam int EXT_W   = NUM_W + OUT_W;

   typedef logic signed [IN_W-1:0]    elem_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ADJ_W-1:0]   adj_type;
   typedef logic signed [DPROD_W-1:0] dprod_type;
   typedef logic signed [DET_W-1:0]   det_type;
   typedef logic [NUM_W-1:0]          num_type;
   typedef logic [DET_W-1:0]          dmag_type;
   typedef logic signed [OUT_W-1:0]   out_type;

   typedef struct packed {
      logic              valid;
      logic              singular;
      logic [N_ELEM-1:0] neg;
   } side_type;

endpackage

>>> hw/rtl/mi3_adjugate.sv
// Five-stage front end: pair products, cofactors, determinant terms, determinant,
// then magnitudes and quotient signs for the divider. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_adjugate import mi3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  elem_type m [N_ELEM],
   output num_type  num [N_ELEM],
   output dmag_type dmag,
   output side_type side
);

   localparam int CP [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int CQ [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int CR [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int CS [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic [4:0] valid_ff;

   prod_type  pa_ff   [N_ELEM];
   prod_type  pb_ff   [N_ELEM];
   elem_type  row1_ff [3];
   adj_type   adj2_ff [N_ELEM];
   elem_type  row2_ff [3];
   adj_type   adj3_ff [N_ELEM];
   dprod_type dp_ff   [3];
   adj_type   adj4_ff [N_ELEM];
   det_type   det_ff;
   num_type   num_ff  [N_ELEM];
   logic [N_ELEM-1:0] neg_ff;
   dmag_type  dmag_ff;
   logic      sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N_ELEM; k++) begin
            pa_ff[k] <= PROD_W'(m[CP[k]]) * PROD_W'(m[CQ[k]]);
            pb_ff[k] <= PROD_W'(m[CR[k]]) * PROD_W'(m[CS[k]]);
            adj2_ff[k] <= ADJ_W'(pa_ff[k]) - ADJ_W'(pb_ff[k]);
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
            num_ff[k] <= NUM_W'(adj4_ff[k][ADJ_W-1] ? -adj4_ff[k] : adj4_ff[k])
                         << (2 * FRAC_BITS);
            neg_ff[k] <= adj4_ff[k][ADJ_W-1] ^ det_ff[DET_W-1];
         end
         for (int j = 0; j < 3; j++) begin
            row1_ff[j] <= m[j];
            row2_ff[j] <= row1_ff[j];
            dp_ff[j]   <= DPROD_W'(row2_ff[j]) * DPROD_W'(adj2_ff[3 * j]);
         end
         det_ff  <= DET_W'(dp_ff[0]) + DET_W'(dp_ff[1]) + DET_W'(dp_ff[2]);
         dmag_ff <= det_ff[DET_W-1] ? dmag_type'(-det_ff) : dmag_type'(det_ff);
         sing_ff <= (det_ff == '0);
      end
   end

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         num[k] = num_ff[k];
      end
      dmag          = dmag_ff;
      side.valid    = valid_ff[4];
      side.singular = sing_ff;
      side.neg      = neg_ff;
   end

endmodule

>>> hw/rtl/mi3_divider.sv
// Nine-lane restoring divider, one quotient bit per lane per stage, NUM_W stages.
// Divisor and sideband ride along the stages. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_divider import mi3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  num_type  num [N_ELEM],
   input  dmag_type dmag,
   input  side_type side_in,
   output num_type  quo [N_ELEM],
   output side_type side_out
);

   dmag_type rem_ff  [NUM_W][N_ELEM];
   num_type  nq_ff   [NUM_W][N_ELEM];
   dmag_type d_ff    [NUM_W];
   side_type side_ff [NUM_W];

   dmag_type rem_in  [NUM_W][N_ELEM];
   num_type  nq_in   [NUM_W][N_ELEM];

   always_comb begin
      logic [DET_W:0] trial;
      logic [DET_W:0] diff;
      dmag_type       r;
      num_type        nq;
      dmag_type       d;
      for (int s = 0; s < NUM_W; s++) begin
         for (int k = 0; k < N_ELEM; k++) begin
            if (s == 0) begin
               r  = '0;
               nq = num[k];
               d  = dmag;
            end else begin
               r  = rem_ff[s-1][k];
               nq = nq_ff[s-1][k];
               d  = d_ff[s-1];
            end
            trial = {r, nq[NUM_W-1]};
            diff  = trial - {1'b0, d};
            if (trial >= {1'b0, d}) begin
               rem_in[s][k] = diff[DET_W-1:0];
               nq_in[s][k]  = {nq[NUM_W-2:0], 1'b1};
            end else begin
               rem_in[s][k] = trial[DET_W-1:0];
               nq_in[s][k]  = {nq[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0]             <= dmag;
         side_ff[0].singular <= side_in.singular;
         side_ff[0].neg      <= side_in.neg;
         for (int s = 1; s < NUM_W; s++) begin
            d_ff[s]             <= d_ff[s-1];
            side_ff[s].singular <= side_ff[s-1].singular;
            side_ff[s].neg      <= side_ff[s-1].neg;
         end
         for (int s = 0; s < NUM_W; s++) begin
            for (int k = 0; k < N_ELEM; k++) begin
               rem_ff[s][k] <= rem_in[s][k];
               nq_ff[s][k]  <= nq_in[s][k];
            end
         end
      end
      if (reset) begin
         for (int s = 0; s < NUM_W; s++) begin
            side_ff[s].valid <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0].valid <= side_in.valid;
         for (int s = 1; s < NUM_W; s++) begin
            side_ff[s].valid <= side_ff[s-1].valid;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         quo[k] = nq_ff[NUM_W-1][k];
      end
      side_out = side_ff[NUM_W-1];
   end

endmodule

>>> hw/rtl/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by adjugate and pipelined division.
// A request passes the adjugate stages, the divider stages and the output register before its result appears.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Latency is set mostly by the restoring divider stages, one per quotient bit.
// Reset (synchronous, active high) clears every valid bit; data registers keep no reset.
`timescale 1ns / 1ps

module matrix_inverse_3x3 import mi3_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [N_ELEM*IN_W-1:0]    req_tdata,  // m11,m12,m13,m21,m22,m23,m31,m32,m33
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [N_ELEM*OUT_W-1:0]   rsp_tdata,  // inv11,inv12,...,inv33
   output logic [1:0]                rsp_tuser   // singular, saturated
);

   localparam logic [EXT_W-1:0] POS_LIM = (EXT_W'(1) << (OUT_W - 1)) - EXT_W'(1);
   localparam logic [EXT_W-1:0] NEG_MAG = EXT_W'(1) << (OUT_W - 1);

   logic     advance;
   elem_type m [N_ELEM];
   num_type  num [N_ELEM];
   dmag_type dmag;
   side_type side_mid;
   num_type  quo [N_ELEM];
   side_type side_end;

   logic                    out_valid_ff;
   logic [N_ELEM*OUT_W-1:0] out_data_ff;
   logic [N_ELEM*OUT_W-1:0] out_data_in;
   logic [1:0]              out_user_ff;
   logic [1:0]              out_user_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         m[k] = req_tdata[k*IN_W +: IN_W];
      end
   end

   mi3_adjugate u_adj (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .m        (m),
      .num      (num),
      .dmag     (dmag),
      .side     (side_mid)
   );

   mi3_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .num      (num),
      .dmag     (dmag),
      .side_in  (side_mid),
      .quo      (quo),
      .side_out (side_end)
   );

   // clip each quotient and apply its sign; a singular matrix gives all zeros
   always_comb begin
      logic [EXT_W-1:0] q;
      logic [EXT_W-1:0] v;
      logic             sat;
      sat = 1'b0;
      for (int k = 0; k < N_ELEM; k++) begin
         q = EXT_W'(quo[k]);
         v = q;
         if (!side_end.neg[k] && q > POS_LIM) begin
            v   = POS_LIM;
            sat = 1'b1;
         end else if (side_end.neg[k] && q > NEG_MAG) begin
            v   = NEG_MAG;
            sat = 1'b1;
         end
         if (side_end.neg[k]) begin
            v = -v;
         end
         out_data_in[k*OUT_W +: OUT_W] = side_end.singular ? '0 : v[OUT_W-1:0];
      end
      out_user_in = {sat && !side_end.singular, side_end.singular};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= side_end.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
